// File: sv/gap_pkg.sv
// ----------------------------------------------------------------------------
// gap_pkg
// Shared widths, register codes, control types and divider states for the
// global average pooling block.
// ----------------------------------------------------------------------------
package gap_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 16;
    localparam int CHAN_IDX_W = 10;
    localparam int DIM_W      = 9;
    localparam int CHAN_CNT_W = 11;
    localparam int DIM_MAX    = 256;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_PLANE_WIDTH   = 2'd0,
        REG_PLANE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } t_reg_idx;

    // register values and a restart request, handed to the front end
    typedef struct packed {
        logic [DIM_W-1:0]      plane_width;
        logic [DIM_W-1:0]      plane_height;
        logic [CHAN_CNT_W-1:0] channel_count;
        logic                  restart;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_div_state;

endpackage

// File: sv/gap_front.sv
// ----------------------------------------------------------------------------
// gap_front
// Takes samples, keeps the running channel sum and plane position, and pushes
// one division request into the queue when a plane completes.
// ----------------------------------------------------------------------------
module gap_front #(
    parameter int MAX_PLANE    = 65536,
    parameter int MAX_CHANNELS = 1024,
    parameter int PLANE_W      = 17,
    parameter int SUM_W        = 33
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gap_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [gap_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_q_full,
    output logic                         o_push,
    output logic [SUM_W-1:0]             o_sum,
    output logic [PLANE_W-1:0]           o_size,
    output logic [gap_pkg::CHAN_IDX_W-1:0] o_chan,
    output logic                         o_last
);
    import gap_pkg::*;

    localparam int CMP_W = CHAN_CNT_W + 2;

    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [PLANE_W-1:0]    r_pos, n_pos;
    logic [CHAN_CNT_W-1:0] r_chan, n_chan;
    logic [DIM_W-1:0]      w_eff, h_eff;
    logic [PROD_W-1:0]     prod;
    logic [PLANE_W-1:0]    size;
    logic [CHAN_CNT_W-1:0] chans;
    logic [CHAN_CNT_W:0]   chan_inc;
    logic                  accept, done, last;

    always_comb begin
        w_eff = (i_cfg.plane_width == '0) ? DIM_W'(1) :
                (i_cfg.plane_width > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : i_cfg.plane_width;
        h_eff = (i_cfg.plane_height == '0) ? DIM_W'(1) :
                (i_cfg.plane_height > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : i_cfg.plane_height;
        prod  = PROD_W'(w_eff) * PROD_W'(h_eff);
        size  = (prod > PROD_W'(MAX_PLANE)) ? PLANE_W'(MAX_PLANE) : PLANE_W'(prod);
        if (i_cfg.channel_count == '0) begin
            chans = CHAN_CNT_W'(1);
        end else if (CMP_W'(i_cfg.channel_count) > CMP_W'(MAX_CHANNELS)) begin
            chans = CHAN_CNT_W'(MAX_CHANNELS);
        end else begin
            chans = i_cfg.channel_count;
        end
    end

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign n_sum    = r_sum + {{(SUM_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
    assign n_pos    = r_pos + PLANE_W'(1);
    assign done     = (n_pos >= size);
    assign chan_inc = {1'b0, r_chan} + (CHAN_CNT_W+1)'(1);
    assign last     = (chan_inc >= {1'b0, chans});
    assign n_chan   = last ? '0 : chan_inc[CHAN_CNT_W-1:0];

    assign o_push = accept && done;
    assign o_sum  = n_sum;
    assign o_size = size;
    assign o_chan = r_chan[CHAN_IDX_W-1:0];
    assign o_last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_chan <= '0;
        end else if (accept) begin
            if (done) begin
                r_sum  <= '0;
                r_pos  <= '0;
                r_chan <= n_chan;
            end else begin
                r_sum  <= n_sum;
                r_pos  <= n_pos;
            end
        end
    end

    a_pos_in_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.restart |=> (r_pos < size) || $past(i_cfg.restart))
        else $error("plane position reached plane size without wrapping");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("request pushed into a full queue");

endmodule

// File: sv/gap_queue.sv
// ----------------------------------------------------------------------------
// gap_queue
// Short first-in first-out queue between the accumulating front end and the
// divider.
// ----------------------------------------------------------------------------
module gap_queue #(
    parameter int WIDTH = 61,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    import gap_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

// File: sv/gap_div.sv
// ----------------------------------------------------------------------------
// gap_div
// Back end: signed sum divided by plane size, one quotient bit per cycle,
// truncated toward zero, into an output register.
// ----------------------------------------------------------------------------
module gap_div #(
    parameter int PLANE_W = 17,
    parameter int SUM_W   = 33
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [SUM_W-1:0]               i_sum,
    input  logic [PLANE_W-1:0]             i_size,
    input  logic [gap_pkg::CHAN_IDX_W-1:0] i_chan,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [gap_pkg::AVG_W-1:0]      o_average,
    output logic [gap_pkg::CHAN_IDX_W-1:0] o_channel_index,
    output logic                           o_last_channel
);
    import gap_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    t_div_state             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [SUM_W-1:0]       r_quo;
    logic [PLANE_W-1:0]     r_rem, r_div;
    logic                   r_neg;
    logic [CHAN_IDX_W-1:0]  r_chan;
    logic                   r_last;
    logic                   r_out_valid;
    logic [AVG_W-1:0]       r_avg;
    logic [CHAN_IDX_W-1:0]  r_out_chan;
    logic                   r_out_last;

    logic                   load, step, out_load;
    logic [PLANE_W:0]       trial;
    logic                   fits;
    logic [SUM_W-1:0]       q_signed;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(1)) n_state = S_HOLD;
            S_HOLD:  if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        load     = 1'b0;
        step     = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE:  load = i_valid;
            S_DIV:   step = 1'b1;
            S_HOLD:  out_load = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    assign o_ready  = load;
    assign trial    = {r_rem, r_quo[SUM_W-1]};
    assign fits     = (trial >= {1'b0, r_div});
    assign q_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_cnt <= CNT_W'(SUM_W);
            end else if (step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_neg  <= i_sum[SUM_W-1];
            r_quo  <= i_sum[SUM_W-1] ? (~i_sum + SUM_W'(1)) : i_sum;
            r_rem  <= '0;
            r_div  <= i_size;
            r_chan <= i_chan;
            r_last <= i_last;
        end else if (step) begin
            // restoring step: remainder stays below the divisor
            r_rem <= fits ? PLANE_W'(trial - {1'b0, r_div}) : trial[PLANE_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
        if (out_load) begin
            r_avg      <= q_signed[AVG_W-1:0];
            r_out_chan <= r_chan;
            r_out_last <= r_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_average       = r_avg;
    assign o_channel_index = r_out_chan;
    assign o_last_channel  = r_out_last;

    a_quotient_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> (r_quo <= SUM_W'(32768)))
        else $error("mean magnitude exceeds sample range");

    a_div_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0))
        else $error("divider running with exhausted bit count");

endmodule

// File: sv/global_average_pooling.sv
// ----------------------------------------------------------------------------
// global_average_pooling
// Per-channel mean of a channel-major feature map of signed Q8.8 samples.
// Flow: a completed plane's sum goes through a two-entry queue to a
// bit-serial divider that takes one plane at a time; input takes one sample
// per cycle while the queue has room and stalls when it is full.
// Reset: synchronous active-low; registers return to 1, sums and counters
// clear, queue and output empty. Any register write restarts the map.
// ----------------------------------------------------------------------------
module global_average_pooling #(
    parameter int MAX_PLANE    = 65536,
    parameter int MAX_CHANNELS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gap_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gap_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gap_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [gap_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [gap_pkg::AVG_W-1:0]        o_average,
    output logic [gap_pkg::CHAN_IDX_W-1:0]   o_channel_index,
    output logic                             o_last_channel
);
    import gap_pkg::*;

    localparam int PLANE_W = $clog2(MAX_PLANE + 1);
    localparam int SUM_W   = SAMPLE_W + PLANE_W;
    localparam int ENTRY_W = SUM_W + PLANE_W + CHAN_IDX_W + 1;

    logic [DIM_W-1:0]      r_width, r_height;
    logic [CHAN_CNT_W-1:0] r_chans;
    t_reg_idx              idx;
    logic                  wr;
    t_cfg                  cfg;

    logic                  push, q_full, q_empty, pop;
    logic [SUM_W-1:0]      f_sum, b_sum;
    logic [PLANE_W-1:0]    f_size, b_size;
    logic [CHAN_IDX_W-1:0] f_chan, b_chan;
    logic                  f_last, b_last;
    logic [ENTRY_W-1:0]    q_in, q_out;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_chans  <= CHAN_CNT_W'(1);
        end else if (wr) begin
            case (idx)
                REG_PLANE_WIDTH:   r_width  <= pwdata[DIM_W-1:0];
                REG_PLANE_HEIGHT:  r_height <= pwdata[DIM_W-1:0];
                REG_CHANNEL_COUNT: r_chans  <= pwdata[CHAN_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PLANE_WIDTH:   prdata = APB_DATA_W'(r_width);
            REG_PLANE_HEIGHT:  prdata = APB_DATA_W'(r_height);
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(r_chans);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        cfg.plane_width   = r_width;
        cfg.plane_height  = r_height;
        cfg.channel_count = r_chans;
        cfg.restart       = wr && (idx == REG_PLANE_WIDTH || idx == REG_PLANE_HEIGHT ||
                                   idx == REG_CHANNEL_COUNT);
    end

    gap_front #(
        .MAX_PLANE    (MAX_PLANE),
        .MAX_CHANNELS (MAX_CHANNELS),
        .PLANE_W      (PLANE_W),
        .SUM_W        (SUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .i_q_full (q_full),
        .o_push   (push),
        .o_sum    (f_sum),
        .o_size   (f_size),
        .o_chan   (f_chan),
        .o_last   (f_last)
    );

    assign q_in = {f_sum, f_size, f_chan, f_last};

    gap_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {b_sum, b_size, b_chan, b_last} = q_out;

    gap_div #(
        .PLANE_W (PLANE_W),
        .SUM_W   (SUM_W)
    ) u_div (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (!q_empty),
        .o_ready         (pop),
        .i_sum           (b_sum),
        .i_size          (b_size),
        .i_chan          (b_chan),
        .i_last          (b_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_average       (o_average),
        .o_channel_index (o_channel_index),
        .o_last_channel  (o_last_channel)
    );

endmodule
